### sv/pacr_pkg.sv
// Package with the word types, state codes and constants of the phase-adaptive victim chooser.
`default_nettype none
package pacr_pkg;

  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned STRIDE_W    = 17;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned SCORE_W     = TIME_W + 2;
  localparam int unsigned STRIDE_LIM  = 1 << 15;

  localparam logic [7:0] MATCH_BONUS_RST  = 8'd32;
  localparam logic [7:0] MRU_BONUS_RST    = 8'd8;
  localparam logic [7:0] PHASE_WINDOW_RST = 8'd32;

  localparam logic [1:0] CFG_MATCH_BONUS  = 2'd0;
  localparam logic [1:0] CFG_MRU_BONUS    = 2'd1;
  localparam logic [1:0] CFG_PHASE_WINDOW = 2'd2;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [10:0]       set_index;
    logic [3:0]        way_index;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] pc;
  } in_word_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       mode_used;
  } out_word_t;

  // Per-set phase detector state.
  typedef struct packed {
    logic             mode;
    logic [CNT_W-1:0] votes_sp;
    logic [CNT_W-1:0] votes_pc;
    logic [CNT_W-1:0] count;
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCORE,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

### sv/phase_adaptive_cache_replacement_top.sv
// Top level of the phase-adaptive victim chooser: sequencer, set memories and scoring loop.
`default_nettype none
// Each word names a set. An access update passes through capture, memory read and write
// back; a victim query passes through capture, read, phase update and the ways, one per
// cycle, through the shared scoring unit, then waits until its result is taken. Only one
// word is in flight; the result of a query leaves through an output register. After reset
// the block clears its set memories one set per cycle and accepts no word until that pass
// ends; configuration writes are taken at any time. Updates give no result; words for a
// set out of range, and updates for a way out of range, are dropped.
module phase_adaptive_cache_replacement_top #(
  parameter int unsigned SETS            = 2048,
  parameter int unsigned WAYS            = 16,
  parameter int unsigned PC_RING_DEPTH   = 8,
  parameter int unsigned ADDRESS_HISTORY = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pacr_pkg::in_word_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pacr_pkg::out_word_t     out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [7:0]         cfg_wdata_i
);

  localparam int unsigned SW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW  = $clog2(WAYS);
  localparam int unsigned PW  = $clog2(PC_RING_DEPTH);
  localparam int unsigned HW  = $clog2(ADDRESS_HISTORY);
  localparam int unsigned AW  = pacr_pkg::ADDR_W;
  localparam int unsigned TW  = pacr_pkg::TIME_W;
  localparam int unsigned STW = pacr_pkg::STRIDE_W;
  localparam int unsigned HCW = $clog2(ADDRESS_HISTORY) + 1;

  // Configuration registers.
  logic [7:0] match_bonus_q, mru_bonus_q, phase_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_bonus_q  <= pacr_pkg::MATCH_BONUS_RST;
      mru_bonus_q    <= pacr_pkg::MRU_BONUS_RST;
      phase_window_q <= pacr_pkg::PHASE_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pacr_pkg::CFG_MATCH_BONUS:  match_bonus_q  <= cfg_wdata_i;
        pacr_pkg::CFG_MRU_BONUS:    mru_bonus_q    <= cfg_wdata_i;
        pacr_pkg::CFG_PHASE_WINDOW: phase_window_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  pacr_pkg::state_e  state_q, state_d;
  pacr_pkg::in_word_t item_q;
  logic [SW-1:0]     clr_q;
  logic [WW-1:0]     wc_q;
  logic [TW-1:0]     time_q;
  logic              mode_q;
  logic signed [pacr_pkg::SCORE_W-1:0] best_q;
  logic [WW-1:0]     victim_q;
  logic              out_valid_q;
  pacr_pkg::out_word_t out_q;

  logic [SW-1:0] set_a;
  logic          set_ok, way_ok, clr_last, wc_last, accept;

  assign set_a    = SW'(item_q.set_index);
  assign set_ok   = (32'(item_q.set_index) < 32'(SETS));
  assign way_ok   = (32'(item_q.way_index) < 32'(WAYS));
  assign clr_last = (32'(clr_q) == 32'(SETS - 1));
  assign wc_last  = (wc_q == WW'(WAYS - 1));
  assign in_ready_o  = (state_q == pacr_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Set memories, one row per set.
  logic [PC_RING_DEPTH*AW-1:0]   pcr_mem [SETS];
  logic [ADDRESS_HISTORY*AW-1:0] adr_mem [SETS];
  logic [PW+HW-1:0]              ptr_mem [SETS];
  logic [STW-1:0]                str_mem [SETS];
  pacr_pkg::phase_t              ph_mem  [SETS];
  logic [WAYS*TW-1:0]            wt_mem  [SETS];
  logic [WAYS*AW-1:0]            wa_mem  [SETS];
  logic [WAYS*AW-1:0]            wp_mem  [SETS];
  logic [WAYS*WW-1:0]            wr_mem  [SETS];

  logic [PC_RING_DEPTH*AW-1:0]   pcr_rd_q, pcr_wd;
  logic [ADDRESS_HISTORY*AW-1:0] adr_rd_q, adr_wd;
  logic [PW+HW-1:0]              ptr_rd_q, ptr_wd;
  logic [STW-1:0]                str_rd_q, str_wd;
  pacr_pkg::phase_t              ph_rd_q, ph_wd;
  logic [WAYS*TW-1:0]            wt_rd_q, wt_wd;
  logic [WAYS*AW-1:0]            wa_rd_q, wa_wd;
  logic [WAYS*AW-1:0]            wp_rd_q, wp_wd;
  logic [WAYS*WW-1:0]            wr_rd_q, wr_wd;
  logic                          we;
  logic [SW-1:0]                 wa;

  assign wa = (state_q == pacr_pkg::ST_CLEAR) ? clr_q : set_a;

  always_ff @(posedge clk_i) begin
    if (we) begin
      pcr_mem[wa] <= pcr_wd;
      adr_mem[wa] <= adr_wd;
      ptr_mem[wa] <= ptr_wd;
      str_mem[wa] <= str_wd;
      ph_mem[wa]  <= ph_wd;
      wt_mem[wa]  <= wt_wd;
      wa_mem[wa]  <= wa_wd;
      wp_mem[wa]  <= wp_wd;
      wr_mem[wa]  <= wr_wd;
    end
    pcr_rd_q <= pcr_mem[set_a];
    adr_rd_q <= adr_mem[set_a];
    ptr_rd_q <= ptr_mem[set_a];
    str_rd_q <= str_mem[set_a];
    ph_rd_q  <= ph_mem[set_a];
    wt_rd_q  <= wt_mem[set_a];
    wa_rd_q  <= wa_mem[set_a];
    wp_rd_q  <= wp_mem[set_a];
    wr_rd_q  <= wr_mem[set_a];
  end

  // Row update for an access: rings, pointers, stride, way stamps and ranks.
  logic [PW-1:0]  pp, pp_nx;
  logic [HW-1:0]  ap, ap_prev, ap_nx;
  logic [AW-1:0]  prev_a;
  logic [AW:0]    dlt, dlt_mag;
  logic [WW-1:0]  wsel, cur_rank;
  logic [HCW-1:0] hits;
  logic [AW:0]    dd;
  logic [AW:0]    st_ext;
  pacr_pkg::phase_t ph_new;

  assign pp      = ptr_rd_q[PW+HW-1:HW];
  assign ap      = ptr_rd_q[HW-1:0];
  assign pp_nx   = (pp == PW'(PC_RING_DEPTH - 1)) ? '0 : pp + PW'(1);
  assign ap_nx   = (ap == HW'(ADDRESS_HISTORY - 1)) ? '0 : ap + HW'(1);
  assign ap_prev = (ap == '0) ? HW'(ADDRESS_HISTORY - 1) : ap - HW'(1);
  assign prev_a  = adr_rd_q[ap_prev*AW +: AW];
  assign dlt     = {1'b0, item_q.address} - {1'b0, prev_a};
  assign dlt_mag = dlt[AW] ? -dlt : dlt;
  assign wsel    = WW'(item_q.way_index);
  assign cur_rank = wr_rd_q[wsel*WW +: WW];
  assign st_ext  = {{(AW+1-STW){str_rd_q[STW-1]}}, str_rd_q};

  // Phase vote over neighboring history entries, then the window decision.
  always_comb begin
    hits = '0;
    dd   = '0;
    for (int unsigned i = 1; i < ADDRESS_HISTORY; i++) begin
      dd = {1'b0, adr_rd_q[i*AW +: AW]} - {1'b0, adr_rd_q[(i-1)*AW +: AW]};
      if ((str_rd_q != '0) && (dd == st_ext)) hits = hits + HCW'(1);
    end
    ph_new = ph_rd_q;
    if (32'(hits) > 32'(ADDRESS_HISTORY / 2)) ph_new.votes_sp = ph_rd_q.votes_sp + 8'd1;
    else ph_new.votes_pc = ph_rd_q.votes_pc + 8'd1;
    ph_new.count = ph_rd_q.count + 8'd1;
    if (ph_new.count >= phase_window_q) begin
      ph_new.mode     = (ph_new.votes_sp > ph_new.votes_pc);
      ph_new.votes_sp = '0;
      ph_new.votes_pc = '0;
      ph_new.count    = '0;
    end
  end

  // Write data: clearing pass, access update or phase write-back of a query.
  always_comb begin
    pcr_wd = pcr_rd_q;
    adr_wd = adr_rd_q;
    ptr_wd = ptr_rd_q;
    str_wd = str_rd_q;
    ph_wd  = ph_rd_q;
    wt_wd  = wt_rd_q;
    wa_wd  = wa_rd_q;
    wp_wd  = wp_rd_q;
    wr_wd  = wr_rd_q;
    we     = 1'b0;
    if (state_q == pacr_pkg::ST_CLEAR) begin
      we     = 1'b1;
      pcr_wd = '0;
      adr_wd = '0;
      ptr_wd = '0;
      str_wd = '0;
      ph_wd  = '0;
      wt_wd  = '0;
      wa_wd  = '0;
      wp_wd  = '0;
      for (int unsigned k = 0; k < WAYS; k++) wr_wd[k*WW +: WW] = WW'(k);
    end else if ((state_q == pacr_pkg::ST_EXEC) && set_ok) begin
      if (item_q.cmd == pacr_pkg::CMD_UPDATE) begin
        we = way_ok;
        pcr_wd[pp*AW +: AW] = item_q.pc;
        adr_wd[ap*AW +: AW] = item_q.address;
        ptr_wd = {pp_nx, ap_nx};
        if ((dlt != '0) && (dlt_mag < (AW+1)'(pacr_pkg::STRIDE_LIM))) str_wd = dlt[STW-1:0];
        wt_wd[wsel*TW +: TW] = time_q;
        wa_wd[wsel*AW +: AW] = item_q.address;
        wp_wd[wsel*AW +: AW] = item_q.pc;
        for (int unsigned k = 0; k < WAYS; k++) begin
          if (wr_rd_q[k*WW +: WW] < cur_rank) wr_wd[k*WW +: WW] = wr_rd_q[k*WW +: WW] + WW'(1);
        end
        wr_wd[wsel*WW +: WW] = '0;
      end else begin
        we    = 1'b1;
        ph_wd = ph_new;
      end
    end
  end

  // Shared scoring unit, one way per cycle.
  logic signed [pacr_pkg::SCORE_W-1:0] score;

  pacr_score #(
    .PCH(PC_RING_DEPTH),
    .AH (ADDRESS_HISTORY),
    .RW (WW)
  ) u_score (
    .mode_i       (mode_q),
    .time_i       (time_q),
    .way_time_i   (wt_rd_q[wc_q*TW +: TW]),
    .way_addr_i   (wa_rd_q[wc_q*AW +: AW]),
    .way_pc_i     (wp_rd_q[wc_q*AW +: AW]),
    .way_rank_i   (wr_rd_q[wc_q*WW +: WW]),
    .pc_ring_i    (pcr_rd_q),
    .addr_ring_i  (adr_rd_q),
    .stride_i     ($signed(str_rd_q)),
    .match_bonus_i(match_bonus_q),
    .mru_bonus_i  (mru_bonus_q),
    .score_o      (score)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pacr_pkg::ST_CLEAR: if (clr_last) state_d = pacr_pkg::ST_IDLE;
      pacr_pkg::ST_IDLE:  if (accept) state_d = pacr_pkg::ST_READ;
      pacr_pkg::ST_READ:  state_d = pacr_pkg::ST_EXEC;
      pacr_pkg::ST_EXEC: begin
        if (set_ok && (item_q.cmd == pacr_pkg::CMD_QUERY)) state_d = pacr_pkg::ST_SCORE;
        else state_d = pacr_pkg::ST_IDLE;
      end
      pacr_pkg::ST_SCORE: if (wc_last) state_d = pacr_pkg::ST_OUT;
      pacr_pkg::ST_OUT:   if (out_ready_i) state_d = pacr_pkg::ST_IDLE;
      default:            state_d = pacr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pacr_pkg::ST_CLEAR;
      clr_q       <= '0;
      wc_q        <= '0;
      time_q      <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pacr_pkg::ST_CLEAR) clr_q <= clr_q + SW'(1);
      if ((state_q == pacr_pkg::ST_EXEC) && set_ok && (item_q.cmd == pacr_pkg::CMD_QUERY)) begin
        time_q <= time_q + TW'(1);
        mode_q <= ph_new.mode;
        wc_q   <= '0;
      end
      if (state_q == pacr_pkg::ST_SCORE) begin
        wc_q <= wc_q + WW'(1);
        if (wc_last) out_valid_q <= 1'b1;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == pacr_pkg::ST_SCORE) begin
      if ((wc_q == '0) || (score < best_q)) begin
        best_q   <= score;
        victim_q <= wc_q;
      end
      if (wc_last) begin
        out_q.victim_way <= ((wc_q == '0) || (score < best_q)) ? 4'(wc_q) : 4'(victim_q);
        out_q.mode_used  <= mode_q;
      end
    end
  end

  // Checks on the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pacr_pkg::ST_CLEAR) |-> (!in_ready_o && !out_valid_o))
    else $error("word taken or result shown during the clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("new word taken while a result waits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == pacr_pkg::ST_READ))
    else $error("accepted word did not start a memory read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (state_q == pacr_pkg::ST_OUT))
    else $error("sequencer left while a result was held");

endmodule
`default_nettype wire

### sv/pacr_score.sv
// Scoring unit: reuse score of one way against the set's histories.
`default_nettype none
module pacr_score #(
  parameter int unsigned PCH = 8,
  parameter int unsigned AH  = 8,
  parameter int unsigned RW  = 4
) (
  input  wire logic                                  mode_i,
  input  wire logic [pacr_pkg::TIME_W-1:0]           time_i,
  input  wire logic [pacr_pkg::TIME_W-1:0]           way_time_i,
  input  wire logic [pacr_pkg::ADDR_W-1:0]           way_addr_i,
  input  wire logic [pacr_pkg::ADDR_W-1:0]           way_pc_i,
  input  wire logic [RW-1:0]                         way_rank_i,
  input  wire logic [PCH*pacr_pkg::ADDR_W-1:0]       pc_ring_i,
  input  wire logic [AH*pacr_pkg::ADDR_W-1:0]        addr_ring_i,
  input  wire logic signed [pacr_pkg::STRIDE_W-1:0]  stride_i,
  input  wire logic [7:0]                            match_bonus_i,
  input  wire logic [7:0]                            mru_bonus_i,
  output logic signed [pacr_pkg::SCORE_W-1:0]        score_o
);

  localparam int unsigned AW = pacr_pkg::ADDR_W;

  logic              pc_hit;
  logic              near_hit;
  logic [AW:0]       st_mag;
  logic [AW:0]       diff;
  logic [AW:0]       diff_mag;
  logic [AW-1:0]     h;

  // Magnitude of the stride, widened to the difference width.
  always_comb begin
    st_mag = (AW+1)'(stride_i[pacr_pkg::STRIDE_W-1] ? -stride_i : stride_i);
  end

  // History compares run in parallel over the ring entries.
  always_comb begin
    pc_hit   = 1'b0;
    near_hit = 1'b0;
    diff     = '0;
    diff_mag = '0;
    h        = '0;
    for (int unsigned i = 0; i < PCH; i++) begin
      if (pc_ring_i[i*AW +: AW] == way_pc_i) pc_hit = 1'b1;
    end
    for (int unsigned i = 0; i < AH; i++) begin
      h        = addr_ring_i[i*AW +: AW];
      diff     = {1'b0, h} - {1'b0, way_addr_i};
      diff_mag = diff[AW] ? -diff : diff;
      if (h == way_addr_i) near_hit = 1'b1;
      if ((st_mag != '0) && (diff_mag <= st_mag)) near_hit = 1'b1;
    end
  end

  // Age minus the bonuses that apply.
  always_comb begin
    logic hit;
    hit = mode_i ? near_hit : pc_hit;
    score_o = $signed({2'b00, time_i - way_time_i})
            - $signed(pacr_pkg::SCORE_W'(hit ? match_bonus_i : 8'd0))
            - $signed(pacr_pkg::SCORE_W'((way_rank_i <= RW'(1)) ? mru_bonus_i : 8'd0));
  end

endmodule
`default_nettype wire
